// ----- hdl/i2d_pkg.sv -----
// ----------------------------------------------------------------------------
// i2d_pkg
// Shared constants and sizing helpers for the integer to decimal text block.
// ----------------------------------------------------------------------------
package i2d_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_FIELD_DEF   = 64;
  localparam int QUEUE_DEPTH     = 2;

  localparam int CHAR_W = 6;
  localparam int CFG_W  = 7;

  // ASCII codes, low six bits
  localparam logic [CHAR_W-1:0] CH_SPACE = 6'd32;
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;

  // Upper bound on decimal digits of a magnitude up to 2**(w-1).
  // 78/256 sits just above log10(2).
  function automatic int ndig_for(input int w);
    return ((w * 78) >> 8) + 1;
  endfunction

  // Width of the digit count field
  function automatic int ndw_for(input int w);
    return $clog2(ndig_for(w) + 1);
  endfunction

  // Queue entry: sign, digit count, packed BCD digits
  function automatic int entry_w_for(input int w);
    return 1 + ndw_for(w) + 4 * ndig_for(w);
  endfunction

endpackage

// ----- hdl/i2d_ifs.sv -----
// ----------------------------------------------------------------------------
// i2d channel interfaces
// Valid/ready channels for the input value, output characters and the
// minimum width register.
// ----------------------------------------------------------------------------
interface i2d_value_if #(parameter int VALUE_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2d_char_if;
  logic       valid;
  logic       ready;
  logic [5:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface i2d_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] min_width;

  modport source (output valid, output min_width, input ready);
  modport sink   (input valid, input min_width, output ready);
endinterface

// ----- hdl/i2d_front.sv -----
// ----------------------------------------------------------------------------
// i2d_front
// Takes a value, splits off the sign, converts the magnitude to BCD two
// bits per cycle and pushes sign, digit count and digits to the queue.
// ----------------------------------------------------------------------------
module i2d_front
  import i2d_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          push_valid,
  input  logic                          push_ready,
  output logic [entry_w_for(VALUE_WIDTH)-1:0] push_data
);

  localparam int MAG_W = VALUE_WIDTH + (VALUE_WIDTH % 2);
  localparam int STEPS = MAG_W / 2;
  localparam int CNT_W = $clog2(STEPS);
  localparam int NDIG  = ndig_for(VALUE_WIDTH);
  localparam int NDW   = ndw_for(VALUE_WIDTH);
  localparam int BCD_W = 4 * NDIG;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]             state;
  logic [CNT_W-1:0]       cnt;
  logic [MAG_W-1:0]       sh;
  logic [BCD_W-1:0]       bcd;
  logic                   neg;
  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;
  logic [NDW-1:0]         ndig;

  // one double-dabble step: add 3 to digits of 5 or more, shift in a bit
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b,
                                               input logic bit_in);
    logic [BCD_W-1:0] a;
    a = b;
    for (int i = 0; i < NDIG; i++) begin
      if (a[4*i +: 4] >= 4'd5) begin
        a[4*i +: 4] = a[4*i +: 4] + 4'd3;
      end
    end
    return {a[BCD_W-2:0], bit_in};
  endfunction

  assign raw = in_value;
  assign mag = raw[VALUE_WIDTH-1] ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;

  assign in_ready   = (state == ST_IDLE);
  assign push_valid = (state == ST_PUSH);

  // highest non-zero digit; zero still has one digit
  always_comb begin
    ndig = NDW'(1);
    for (int i = 1; i < NDIG; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        ndig = NDW'(i + 1);
      end
    end
  end

  assign push_data = {neg, ndig, bcd};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (cnt == CNT_W'(0)) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (push_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      neg <= raw[VALUE_WIDTH-1];
      sh  <= MAG_W'(mag);
      bcd <= '0;
      cnt <= CNT_W'(STEPS - 1);
    end else if (state == ST_CONV) begin
      bcd <= dabble(dabble(bcd, sh[MAG_W-1]), sh[MAG_W-2]);
      sh  <= {sh[MAG_W-3:0], 2'b00};
      cnt <= cnt - CNT_W'(1);
    end
  end

endmodule

// ----- hdl/i2d_fifo.sv -----
// ----------------------------------------------------------------------------
// i2d_fifo
// Short register queue between the converter and the character emitter.
// ----------------------------------------------------------------------------
module i2d_fifo
  import i2d_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != CNT_W'(0));
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hdl/i2d_back.sv -----
// ----------------------------------------------------------------------------
// i2d_back
// Pops a converted entry and emits padding, sign and digits, one character
// per cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module i2d_back
  import i2d_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int MAX_FIELD   = MAX_FIELD_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [CFG_W-1:0]                    min_width,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  logic [entry_w_for(VALUE_WIDTH)-1:0] pop_data,
  i2d_char_if.source                          char_ch
);

  localparam int NDIG    = ndig_for(VALUE_WIDTH);
  localparam int NDW     = ndw_for(VALUE_WIDTH);
  localparam int BCD_W   = 4 * NDIG;
  localparam int DIW     = $clog2(NDIG);
  localparam int REM_MAX = (MAX_FIELD > NDIG + 1) ? MAX_FIELD : NDIG + 1;
  localparam int REM_W   = $clog2(REM_MAX + 1);

  logic              busy;
  logic              neg;
  logic [NDW-1:0]    ndig;
  logic [BCD_W-1:0]  bcd;
  logic [REM_W-1:0]  rem;
  logic              ovalid;
  logic [CHAR_W-1:0] code;
  logic              olast;

  logic              pop_neg;
  logic [NDW-1:0]    pop_ndig;
  logic [BCD_W-1:0]  pop_bcd;
  logic [REM_W-1:0]  len;
  logic [REM_W-1:0]  pad;
  logic [REM_W-1:0]  total;
  logic [REM_W-1:0]  ndig_w;
  logic [REM_W-1:0]  rem_m1;
  logic [DIW-1:0]    didx;
  logic [CHAR_W-1:0] ch;
  logic              advance;

  assign {pop_neg, pop_ndig, pop_bcd} = pop_data;

  assign len   = REM_W'(pop_ndig) + REM_W'(pop_neg);
  assign pad   = (min_width > CFG_W'(MAX_FIELD)) ? REM_W'(MAX_FIELD) : REM_W'(min_width);
  assign total = (pad > len) ? pad : len;

  assign pop_ready = !busy;
  assign advance   = busy && (!ovalid || char_ch.ready);

  // character at position rem, counted from the right starting at 1
  assign ndig_w = REM_W'(ndig);
  assign rem_m1 = rem - REM_W'(1);
  assign didx   = rem_m1[DIW-1:0];

  always_comb begin
    if (rem <= ndig_w) begin
      ch = CH_ZERO + {2'b00, bcd[didx*4 +: 4]};
    end else if (neg && rem == ndig_w + REM_W'(1)) begin
      ch = CH_MINUS;
    end else begin
      ch = CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (advance) begin
        ovalid <= 1'b1;
        if (rem == REM_W'(1)) begin
          busy <= 1'b0;
        end
      end else if (char_ch.ready) begin
        ovalid <= 1'b0;
      end
      if (!busy && pop_valid) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && pop_valid) begin
      neg  <= pop_neg;
      ndig <= pop_ndig;
      bcd  <= pop_bcd;
      rem  <= total;
    end else if (advance) begin
      rem <= rem_m1;
    end
    if (advance) begin
      code  <= ch;
      olast <= (rem == REM_W'(1));
    end
  end

  assign char_ch.valid     = ovalid;
  assign char_ch.char_code = code;
  assign char_ch.last      = olast;

endmodule

// ----- hdl/int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Signed integer to right-aligned decimal ASCII text, one character per
// request on the output channel.
// ----------------------------------------------------------------------------
// Each input request carries one two's complement value; the block answers
// with its decimal text, most significant character first, the final one
// flagged by last. Zero gives "0", negatives get a leading '-', and the most
// negative value is exact. Text shorter than min_width is padded on the left
// with spaces (min_width above MAX_FIELD counts as MAX_FIELD). The front
// converter turns each value into BCD with a two-bit-per-cycle shift loop,
// and the emitter gives one character per cycle while the receiver is ready,
// fetching the next entry only once the previous run is done; the slower of
// the two sets the sustained rate. A two-entry queue between
// them lets a new value be converted while the previous one is still being
// sent. min_width is written through the cfg channel, which is always ready;
// write it only while the block is idle. Reset is synchronous, active high.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii
  import i2d_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int MAX_FIELD   = MAX_FIELD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  i2d_value_if.sink  value_ch,
  i2d_cfg_if.sink    cfg,
  i2d_char_if.source char_ch
);

  localparam int ENTRY_W = entry_w_for(VALUE_WIDTH);

  // minimum width register
  logic [CFG_W-1:0] min_width;

  // converter to queue
  logic               push_valid;
  logic               push_ready;
  logic [ENTRY_W-1:0] push_data;

  // queue to emitter
  logic               pop_valid;
  logic               pop_ready;
  logic [ENTRY_W-1:0] pop_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_width <= '0;
    end else if (cfg.valid) begin
      min_width <= cfg.min_width;
    end
  end

  // sign split and binary to BCD
  i2d_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (value_ch.valid),
    .in_ready   (value_ch.ready),
    .in_value   (value_ch.value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decouples conversion from emission
  i2d_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // padding, sign and digits out
  i2d_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_FIELD   (MAX_FIELD)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .min_width (min_width),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .char_ch   (char_ch)
  );

endmodule

// ----- hdl/i2d_checker.sv -----
// ----------------------------------------------------------------------------
// i2d_checker
// Port-level assertions for int_to_decimal_ascii, bound to the top level.
// ----------------------------------------------------------------------------
module i2d_checker
  import i2d_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] char_code,
  input logic              last,
  input logic              cfg_ready
);

  // a stalled character stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  // only space, minus or a digit ever leaves
  a_code_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code == CH_SPACE) || (char_code == CH_MINUS) ||
                  ((char_code >= CH_ZERO) && (char_code <= CH_ZERO + 6'd9)))
    else $error("illegal character code");

  // a sign or space can never end a run
  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> (char_code >= CH_ZERO) && (char_code <= CH_ZERO + 6'd9))
    else $error("run ends on a non-digit");

  // register port never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("cfg channel not ready");

  // nothing offered straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind int_to_decimal_ascii i2d_checker u_i2d_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (char_ch.valid),
  .out_ready (char_ch.ready),
  .char_code (char_ch.char_code),
  .last      (char_ch.last),
  .cfg_ready (cfg.ready)
);

// ----- tb/sv/tb_int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// tb_int_to_decimal_ascii
// Self-checking testbench for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
// A short table of directed values comes first. Some rows carry their text
// typed in and the rest go through the local text predictor. Random values
// follow in three idling phases, with min_width rewritten between batches
// while the block is idle. Each character request leaving the block is
// checked against the oldest expected character, for both code and last.
// ----------------------------------------------------------------------------
module tb_int_to_decimal_ascii;
  import i2d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_WIDTH = VALUE_WIDTH_DEF;
  localparam int MAX_FIELD   = MAX_FIELD_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int BATCHES     = 8;
  localparam int BATCH_LEN   = 10;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  // one expected character of a run
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_rec_t;

  logic clk;
  logic rst;

  i2d_value_if #(.VALUE_WIDTH(VALUE_WIDTH)) value_ch ();
  i2d_cfg_if                                cfg ();
  i2d_char_if                               char_ch ();

  int_to_decimal_ascii #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_FIELD  (MAX_FIELD)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .value_ch(value_ch),
    .cfg     (cfg),
    .char_ch (char_ch)
  );

  // expected characters, oldest first
  char_rec_t text_q[$];

  // local copy of the min_width register
  logic [CFG_W-1:0] width_reg;
  int               cur_width;

  int send_idle_pct;
  int recv_idle_pct;

  int cycles;
  int n_values;
  int n_chars;
  int n_width_writes;
  int n_mismatch;

  // directed table; an empty text means "use the predictor"
  value_t dir_val[$];
  int     dir_w[$];
  string  dir_txt[$];

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Text predictor: decimal digits, sign, left padding, last flag
  // --------------------------------------------------------------------------
  function automatic void predict_text(input value_t v);
    logic [CHAR_W-1:0]      txt [0:127];
    logic [VALUE_WIDTH-1:0] mag;
    logic                   neg;
    int                     len;
    int                     pad_to;
    int                     total;
    char_rec_t              rec;
    neg = v[VALUE_WIDTH-1];
    // unsigned negate keeps the most negative value exact
    mag = neg ? (~v + 1'b1) : v;
    len = 0;
    do begin
      txt[len] = CH_ZERO + CHAR_W'(mag % 10);
      len++;
      mag = mag / 10;
    end while (mag != 0);
    if (neg) begin
      txt[len] = CH_MINUS;
      len++;
    end
    // widths above the field limit are clamped
    pad_to = (int'(width_reg) > MAX_FIELD) ? MAX_FIELD : int'(width_reg);
    total  = (pad_to > len) ? pad_to : len;
    while (len < total) begin
      txt[len] = CH_SPACE;
      len++;
    end
    for (int k = 0; k < total; k++) begin
      rec.code = txt[total-1-k];
      rec.last = (k == total - 1);
      text_q.push_back(rec);
    end
  endfunction

  // typed-in expected text
  function automatic void load_text(input string s);
    char_rec_t rec;
    byte       c;
    for (int i = 0; i < s.len(); i++) begin
      c        = s[i];
      rec.code = c[CHAR_W-1:0];
      rec.last = (i == s.len() - 1);
      text_q.push_back(rec);
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // --------------------------------------------------------------------------
  // Output monitor, sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    char_rec_t exp_rec;
    cycles++;
    if (!rst && char_ch.valid && char_ch.ready) begin
      n_chars++;
      if (text_q.size() == 0) begin
        note_mismatch($sformatf("unexpected char %0d last %0b",
                                char_ch.char_code, char_ch.last));
      end else begin
        exp_rec = text_q.pop_front();
        if (char_ch.char_code !== exp_rec.code)
          note_mismatch($sformatf("char_code exp %0d got %0d",
                                  exp_rec.code, char_ch.char_code));
        if (char_ch.last !== exp_rec.last)
          note_mismatch($sformatf("last exp %0b got %0b (char %0d)",
                                  exp_rec.last, char_ch.last, exp_rec.code));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready stalls at random, changed at the falling edge
  // --------------------------------------------------------------------------
  initial begin
    char_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      char_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d chars still expected", cycles, text_q.size());
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Hold the sender off until every expected character has arrived.
  task automatic wait_idle();
    value_ch.valid = 1'b0;
    while (text_q.size() != 0) @(negedge clk);
    // small margin for the converter pipeline to settle
    repeat (4) @(negedge clk);
  endtask

  // min_width write, only ever from idle
  task automatic set_width(input int w);
    wait_idle();
    cfg.valid     = 1'b1;
    cfg.min_width = CFG_W'(w);
    do @(posedge clk); while (!cfg.ready);
    width_reg = CFG_W'(w);
    cur_width = w;
    n_width_writes++;
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // One value request. valid stays high on return so back-to-back requests
  // do not drop it; the caller lowers it through wait_idle.
  task automatic send_value(input value_t v, input string txt);
    while ($urandom_range(99) < send_idle_pct) begin
      value_ch.valid = 1'b0;
      value_ch.value = $urandom;
      @(negedge clk);
    end
    value_ch.valid = 1'b1;
    value_ch.value = v;
    do @(posedge clk); while (!value_ch.ready);
    if (txt.len() != 0)
      load_text(txt);
    else
      predict_text(v);
    n_values++;
    @(negedge clk);
  endtask

  task automatic add_row(input value_t v, input int w, input string s);
    dir_val.push_back(v);
    dir_w.push_back(w);
    dir_txt.push_back(s);
  endtask

  // random values: full range, small, 16-bit signed, around powers of ten, extremes
  function automatic value_t pick_value();
    value_t p;
    case ($urandom_range(9))
      4: begin
        p = value_t'($urandom_range(20));
      end
      5: begin
        p = 1;
        repeat ($urandom_range(9)) p = p * 10;
        p = p - value_t'($urandom_range(1));
      end
      6: begin
        case ($urandom_range(4))
          0: p = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
          1: p = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
          2: p = '0;
          3: p = '1;
          default: p = {1'b1, {(VALUE_WIDTH-2){1'b0}}, 1'b1};
        endcase
        return p;
      end
      7: begin
        p = value_t'($signed(16'($urandom)));
        return p;
      end
      default: begin
        p = $urandom;
        return p;
      end
    endcase
    if ($urandom_range(1)) p = -p;
    return p;
  endfunction

  // mostly small widths, with the boundary and clamped cases mixed in
  function automatic int pick_width();
    case ($urandom_range(9))
      0:       return 0;
      1:       return MAX_FIELD;
      2:       return (1 << CFG_W) - 1;
      3:       return $urandom_range((1 << CFG_W) - 2, MAX_FIELD + 1);
      4:       return $urandom_range(12, 11);
      default: return $urandom_range(14);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    value_ch.valid = 1'b0;
    value_ch.value = '0;
    cfg.valid      = 1'b0;
    cfg.min_width  = '0;
    width_reg      = '0;
    cur_width      = -1;
    send_idle_pct  = 13;
    recv_idle_pct  = 58;
    cycles         = 0;
    n_values       = 0;
    n_chars        = 0;
    n_width_writes = 0;
    n_mismatch     = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table: value, min_width, expected text (empty: predicted)
    add_row(32'sd0,          0,  "0");
    add_row(32'sd2147483647, 0,  "2147483647");
    add_row(32'h8000_0000,   0,  "-2147483648");
    add_row(-32'sd1,         0,  "-1");
    add_row(32'sd1,          0,  "1");
    add_row(32'sd9,          0,  "");
    add_row(32'sd10,         0,  "");
    add_row(-32'sd10,        0,  "");
    add_row(32'sd999999999,  0,  "");
    add_row(32'sd1000000000, 0,  "");
    add_row(32'sd0,          1,  "0");
    add_row(32'sd0,          5,  "    0");
    add_row(-32'sd7,         3,  " -7");
    // text longer than the width: no padding
    add_row(32'sd12345,      3,  "12345");
    add_row(32'h8000_0000,   11, "-2147483648");
    add_row(32'h8000_0000,   12, " -2147483648");
    add_row(32'sd42,         64, "");
    // widths above the field limit clamp to it
    add_row(32'sd42,         65, "");
    add_row(-32'sd5,         127, "");
    add_row(32'h7FFF_FFFF,   127, "");
    add_row(32'sd0,          0,  "0");

    for (int i = 0; i < dir_val.size(); i++) begin
      if (dir_w[i] != cur_width) set_width(dir_w[i]);
      send_value(dir_val[i], dir_txt[i]);
    end

    // random phases: sender-light, receiver-light, then no idling at all
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 13; recv_idle_pct = 58; end
        1: begin send_idle_pct = 58; recv_idle_pct = 13; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int b = 0; b < BATCHES; b++) begin
        // each write drains the block first, so the sender pauses here
        set_width(pick_width());
        repeat (BATCH_LEN) send_value(pick_value(), "");
      end
    end

    wait_idle();
    repeat (40) @(negedge clk);
    if (text_q.size() != 0) note_mismatch("expected chars left over at end");

    $display("covered %0d values and %0d characters over %0d min_width settings,",
             n_values, n_chars, n_width_writes);
    $display("three idling phases, %0d mismatches", n_mismatch);
    if (n_mismatch == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
